// ===== hw/rtl/pth_pkg.sv =====
// pth_pkg: shared types, codes and constants of the PC trace history buffer.
// No dependencies; imported by every module of the block.
package pth_pkg;

  localparam int MAX_DEPTH = 1024;
  localparam int MIN_DEPTH = 64;
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int CNT_W     = 11;
  localparam int PC_W      = 32;
  localparam int DSP_PC_W  = 16;
  localparam int RSN_W     = 3;
  localparam int REQ_W     = 2;
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
  localparam int TRK_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD = 2'd0,
    REQ_MARK   = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NOP    = 2'd3
  } pth_req_t;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_MARK,
    OP_QUERY,
    OP_ECHO
  } pth_op_t;

  typedef enum logic [0:0] {
    REG_TRACK_MODE   = 1'b0,
    REG_DEPTH_IN_USE = 1'b1
  } pth_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN
  } pth_bk_state_t;

  typedef struct packed {
    logic [PC_W-1:0]  pc;
    logic             dsp;
    logic [RSN_W-1:0] reason;
  } pth_entry_t;

  typedef struct packed {
    pth_op_t          op;
    logic             dsp;
    logic [PC_W-1:0]  pc_key;
    logic [PC_W-1:0]  echo_pc;
    logic [PC_W-1:0]  low_bound;
    logic [RSN_W-1:0] reason;
  } pth_item_t;

  typedef struct packed {
    logic [TRK_W-1:0] track_mode;
    logic [CNT_W-1:0] depth;
    logic             clear;
  } pth_cfg_t;

  function automatic logic [CNT_W-1:0] clamp_depth(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] d;
    d = v;
    if (v < CNT_W'(MIN_DEPTH)) d = CNT_W'(MIN_DEPTH);
    else if (v > CNT_W'(MAX_DEPTH)) d = CNT_W'(MAX_DEPTH);
    return d;
  endfunction

endpackage

// ===== hw/rtl/pth_cfg.sv =====
// pth_cfg: APB-style register file (track mode, depth in use).
// Depends on pth_pkg; raises a history clear pulse when a value changes.
module pth_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pth_pkg::pth_cfg_t            cfg
);
  import pth_pkg::*;

  logic [TRK_W-1:0] track_r, track_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic             clear;
  logic             wr;
  logic [CNT_W-1:0] d_new;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign d_new  = clamp_depth(pwdata[CNT_W-1:0]);

  always_comb begin
    track_nxt = track_r;
    depth_nxt = depth_r;
    clear     = 1'b0;
    if (wr) begin
      unique case (pth_reg_t'(paddr[2]))
        REG_TRACK_MODE: begin
          track_nxt = pwdata[TRK_W-1:0];
          clear     = (pwdata[TRK_W-1:0] != track_r);
        end
        REG_DEPTH_IN_USE: begin
          depth_nxt = d_new;
          clear     = (d_new != depth_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
      depth_r <= CNT_W'(MIN_DEPTH);
    end else begin
      track_r <= track_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_comb begin
    unique case (pth_reg_t'(paddr[2]))
      REG_TRACK_MODE:   prdata = {{(32-TRK_W){1'b0}}, track_r};
      REG_DEPTH_IN_USE: prdata = {{(32-CNT_W){1'b0}}, depth_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.track_mode = track_r;
  assign cfg.depth      = depth_r;
  assign cfg.clear      = clear;

endmodule

// ===== hw/rtl/pth_front.sv =====
// pth_front: classifies an incoming request into a back-end operation.
// Depends on pth_pkg; masks DSP PCs, forms the query window, folds trivial queries.
module pth_front (
  input  logic [pth_pkg::REQ_W-1:0] req_type,
  input  logic                      processor,
  input  logic [pth_pkg::PC_W-1:0]  prog_counter,
  input  logic [pth_pkg::PC_W-1:0]  window_offset,
  input  logic [pth_pkg::RSN_W-1:0] reason_code,
  input  logic [pth_pkg::TRK_W-1:0] track_mode,
  output pth_pkg::pth_item_t        item
);
  import pth_pkg::*;

  logic [PC_W-1:0] pc_key;
  logic            tracked;

  assign pc_key  = processor ? {{(PC_W-DSP_PC_W){1'b0}}, prog_counter[DSP_PC_W-1:0]}
                             : prog_counter;
  assign tracked = processor ? track_mode[1] : track_mode[0];

  always_comb begin
    item.dsp       = processor;
    item.pc_key    = pc_key;
    item.low_bound = pc_key - window_offset;
    item.reason    = reason_code;
    item.echo_pc   = prog_counter;
    unique case (pth_req_t'(req_type))
      REQ_RECORD: item.op = OP_RECORD;
      REQ_MARK:   item.op = OP_MARK;
      REQ_QUERY: begin
        item.echo_pc = pc_key;
        item.op      = (window_offset == '0 || !tracked) ? OP_ECHO : OP_QUERY;
      end
      default:    item.op = OP_ECHO;
    endcase
  end

endmodule

// ===== hw/rtl/pth_queue.sv =====
// pth_queue: short word queue between front and back end.
// Depends on pth_pkg for the item type and depth.
module pth_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pth_pkg::pth_item_t push_item,
  input  logic               pop,
  output pth_pkg::pth_item_t head,
  output logic               not_empty,
  output logic               full
);
  import pth_pkg::*;

  pth_item_t         slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == QCNT_W'(Q_DEPTH));
  assign head      = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) wptr_nxt = (wptr_r == QPTR_W'(Q_DEPTH-1)) ? '0 : wptr_r + 1'b1;
    if (pop)  rptr_nxt = (rptr_r == QPTR_W'(Q_DEPTH-1)) ? '0 : rptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_item;
  end

endmodule

// ===== hw/rtl/pth_back.sv =====
// pth_back: executes operations on the trace ring (record, mark, query scan).
// Depends on pth_pkg; holds the trace memory, ring pointers and repeat counter.
module pth_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pth_pkg::pth_cfg_t        cfg,
  input  logic                     q_valid,
  input  pth_pkg::pth_item_t       q_item,
  output logic                     q_pop,
  output logic                     res_valid,
  output logic [pth_pkg::PC_W-1:0] res_answer,
  output logic [31:0]              res_repeat,
  output logic [pth_pkg::CNT_W-1:0] res_held
);
  import pth_pkg::*;

  pth_entry_t        mem [MAX_DEPTH];
  pth_entry_t        rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pth_entry_t        mem_wdata;

  pth_bk_state_t     state_r, state_nxt;
  logic [ADDR_W-1:0] newest_r, newest_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [31:0]       rep_r, rep_nxt;
  logic [PC_W-1:0]   npc_r, npc_nxt;
  logic              ndsp_r, ndsp_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [PC_W-1:0]   first_r, first_nxt;
  logic [PC_W-1:0]   low_r, low_nxt;
  logic              qdsp_r, qdsp_nxt;
  logic              vld_r, vld_nxt;
  logic [PC_W-1:0]   ans_r, ans_nxt;

  logic              hit;
  logic [PC_W-1:0]   first_cmb;
  logic              repeat_hit;
  logic [ADDR_W-1:0] slot_inc;

  assign hit = rd_vld_r && (rd_q.dsp == qdsp_r) && (rd_q.pc >= low_r) && (rd_q.pc < first_r);
  assign first_cmb  = hit ? rd_q.pc : first_r;
  assign repeat_hit = (fill_r != '0) && (ndsp_r == q_item.dsp) && (npc_r == q_item.pc_key);
  assign slot_inc   = ({1'b0, newest_r} + 1'b1 == CNT_W'(cfg.depth)) ? '0 : newest_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    newest_nxt = newest_r;
    fill_nxt   = fill_r;
    rep_nxt    = rep_r;
    npc_nxt    = npc_r;
    ndsp_nxt   = ndsp_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    rd_vld_nxt = 1'b0;
    first_nxt  = first_cmb;
    low_nxt    = low_r;
    qdsp_nxt   = qdsp_r;
    vld_nxt    = 1'b0;
    ans_nxt    = ans_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = newest_r;
    mem_wdata  = '{pc: npc_r, dsp: ndsp_r, reason: q_item.reason};
    unique case (state_r)
      BK_IDLE: begin
        if (cfg.clear) begin
          newest_nxt = '0;
          fill_nxt   = '0;
          rep_nxt    = '0;
        end else if (q_valid) begin
          q_pop   = 1'b1;
          ans_nxt = q_item.echo_pc;
          unique case (q_item.op)
            OP_RECORD: begin
              vld_nxt = 1'b1;
              if (repeat_hit) begin
                if (rep_r != '1) rep_nxt = rep_r + 1'b1;
              end else begin
                rep_nxt    = '0;
                newest_nxt = slot_inc;
                npc_nxt    = q_item.pc_key;
                ndsp_nxt   = q_item.dsp;
                mem_we     = 1'b1;
                mem_waddr  = slot_inc;
                mem_wdata  = '{pc: q_item.pc_key, dsp: q_item.dsp, reason: '0};
                if (fill_r < cfg.depth) fill_nxt = fill_r + 1'b1;
              end
            end
            OP_MARK: begin
              vld_nxt = 1'b1;
              mem_we  = (fill_r != '0);
            end
            OP_QUERY: begin
              if (fill_r == '0) begin
                vld_nxt = 1'b1;
              end else begin
                state_nxt = BK_SCAN;
                addr_nxt  = (fill_r == cfg.depth) ? '0 : ADDR_W'(1);
                left_nxt  = fill_r;
                first_nxt = q_item.pc_key;
                low_nxt   = q_item.low_bound;
                qdsp_nxt  = q_item.dsp;
              end
            end
            default: vld_nxt = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        rd_vld_nxt = 1'b1;
        addr_nxt   = addr_r + 1'b1;
        left_nxt   = left_r - 1'b1;
        if (left_r == CNT_W'(1)) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        vld_nxt   = 1'b1;
        ans_nxt   = first_cmb;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      newest_r <= '0;
      fill_r   <= '0;
      rep_r    <= '0;
      rd_vld_r <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      newest_r <= newest_nxt;
      fill_r   <= fill_nxt;
      rep_r    <= rep_nxt;
      rd_vld_r <= rd_vld_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    npc_r   <= npc_nxt;
    ndsp_r  <= ndsp_nxt;
    addr_r  <= addr_nxt;
    left_r  <= left_nxt;
    first_r <= first_nxt;
    low_r   <= low_nxt;
    qdsp_r  <= qdsp_nxt;
    ans_r   <= ans_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[addr_r];
  end

  assign res_valid  = vld_r;
  assign res_answer = ans_r;
  assign res_repeat = rep_r;
  assign res_held   = fill_r;

endmodule

// ===== hw/rtl/pc_trace_history_buffer.sv =====
// pc_trace_history_buffer: top level of the two-processor PC trace ring.
// Depends on pth_pkg, pth_cfg, pth_front, pth_queue and pth_back.
//
// Requests enter through a two-word queue; busy is high only while that queue
// is full. Except while a history clear is raised, the back end takes one word
// per cycle for record, mark, no-op and trivial queries (zero offset, untracked
// processor, empty ring), with the result on out_valid in the next cycle. A
// scanning query reads the held entries, one per cycle, through the single read
// port of the 1024-entry trace memory and holds off new words until it ends.
// Results are shown for one cycle only; the receiver must take every strobe. Trace
// memory is not cleared after reset; only entries inside the fill level are read.
module pc_trace_history_buffer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pth_pkg::REQ_W-1:0]  in_req_type,
  input  logic                       in_processor,
  input  logic [pth_pkg::PC_W-1:0]   in_prog_counter,
  input  logic [pth_pkg::PC_W-1:0]   in_window_offset,
  input  logic [pth_pkg::RSN_W-1:0]  in_reason_code,
  output logic                       out_valid,
  output logic [pth_pkg::PC_W-1:0]   out_answer_addr,
  output logic [31:0]                out_repeat_total,
  output logic [pth_pkg::CNT_W-1:0]  out_entries_held,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pth_pkg::*;

  pth_cfg_t  cfg_s;
  pth_item_t front_item;
  pth_item_t q_head;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  logic      q_full;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  pth_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg_s)
  );

  pth_front u_front (
    .req_type      (in_req_type),
    .processor     (in_processor),
    .prog_counter  (in_prog_counter),
    .window_offset (in_window_offset),
    .reason_code   (in_reason_code),
    .track_mode    (cfg_s.track_mode),
    .item          (front_item)
  );

  pth_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  pth_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_s),
    .q_valid    (q_not_empty),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .res_valid  (out_valid),
    .res_answer (out_answer_addr),
    .res_repeat (out_repeat_total),
    .res_held   (out_entries_held)
  );

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_entries_held <= cfg_s.depth)
    else $error("fill level above depth in use");

  a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_s.clear |=> out_entries_held >= $past(out_entries_held))
    else $error("fill level dropped without a history clear");

  a_rep_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_repeat_total != '0) |-> out_entries_held != '0)
    else $error("repeat count on an empty ring");

  a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("back end took a word from an empty queue");

endmodule
